/* rtl/core/six_digit_nixie_cathode_encoder_top_macros.svh */
// Assertion macros shared by the nixie cathode encoder modules.
`ifndef SIX_DIGIT_NIXIE_CATHODE_ENCODER_TOP_MACROS_SVH
`define SIX_DIGIT_NIXIE_CATHODE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/nce_pkg.sv */
// Package with types, constants and digit helpers for the nixie cathode encoder.
package nce_pkg;

  localparam int unsigned NUM_TUBES   = 6;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [19:0] MAX_SHOWN  = 20'd999999;
  // ceil(2^30 / 1000); exact for every quotient of a 20-bit value.
  localparam logic [20:0] RECIP_1000 = 21'd1073742;

  typedef logic [3:0] digit_t;
  typedef logic [5:0] cpos_t;

  // Bit position in the 64-bit pattern, per tube (most significant first), per digit.
  localparam cpos_t CATHODE_POS [NUM_TUBES][NUM_DIGITS] = '{
    '{6'd57, 6'd63, 6'd62, 6'd61, 6'd60, 6'd59, 6'd58, 6'd54, 6'd55, 6'd56},
    '{6'd48, 6'd53, 6'd52, 6'd51, 6'd50, 6'd49, 6'd44, 6'd45, 6'd46, 6'd47},
    '{6'd34, 6'd39, 6'd41, 6'd42, 6'd43, 6'd40, 6'd38, 6'd37, 6'd36, 6'd35},
    '{6'd25, 6'd31, 6'd30, 6'd32, 6'd33, 6'd29, 6'd28, 6'd27, 6'd26, 6'd24},
    '{6'd17, 6'd19, 6'd21, 6'd13, 6'd16, 6'd12, 6'd15, 6'd20, 6'd23, 6'd18},
    '{6'd5,  6'd7,  6'd9,  6'd3,  6'd4,  6'd1,  6'd2,  6'd11, 6'd6,  6'd8 }
  };

  typedef struct packed {
    logic [9:0]  thou;
    logic [19:0] value;
    logic        clamped;
  } split_t;

  typedef struct packed {
    logic [9:0] thou;
    logic [9:0] rest;
    logic       clamped;
  } part_t;

  typedef struct packed {
    digit_t hund;
    digit_t tens;
    digit_t units;
  } trio_t;

  // Splits a value below 1000 into three decimal digits by reciprocal multiplication.
  function automatic trio_t to_trio(input logic [9:0] x);
    logic [15:0] ph;
    logic [6:0]  y;
    logic [13:0] pt;
    trio_t       d;
    ph      = 16'(x) * 16'd41;
    d.hund  = digit_t'(ph >> 12);
    y       = 7'(x - 10'(d.hund) * 10'd100);
    pt      = 14'(y) * 14'd103;
    d.tens  = digit_t'(pt >> 10);
    d.units = digit_t'(y - 7'(d.tens) * 7'd10);
    return d;
  endfunction

  // One-hot cathode bit for a tube and digit.
  function automatic logic [63:0] cathode_mask(input logic [2:0] tube, input digit_t d);
    return 64'(1) << CATHODE_POS[tube][d];
  endfunction

endpackage

/* rtl/core/nce_divk.sv */
// Pipeline stage that clamps the value and takes its thousands by reciprocal multiply.
module nce_divk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [19:0]     value,
  output logic            out_valid,
  input  logic            out_ready,
  output nce_pkg::split_t out_data
);
  import nce_pkg::*;

  logic        valid_r, valid_nxt;
  split_t      data_r, data_nxt;
  logic        over;
  logic [19:0] clip;
  logic [40:0] prod;

  always_comb begin
    over          = value > MAX_SHOWN;
    clip          = over ? MAX_SHOWN : value;
    prod          = 41'(clip) * 41'(RECIP_1000);
    data_nxt.thou    = prod[RECIP_SHIFT +: 10];
    data_nxt.value   = clip;
    data_nxt.clamped = over;
    in_ready      = !valid_r || out_ready;
    valid_nxt     = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/core/nce_rem.sv */
// Pipeline stage that forms the part of the value below one thousand.
`include "six_digit_nixie_cathode_encoder_top_macros.svh"
module nce_rem (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nce_pkg::split_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output nce_pkg::part_t  out_data
);
  import nce_pkg::*;

  logic  valid_r, valid_nxt;
  part_t data_r, data_nxt;

  always_comb begin
    data_nxt.thou    = in_data.thou;
    data_nxt.rest    = 10'(in_data.value - 20'(in_data.thou) * 20'd1000);
    data_nxt.clamped = in_data.clamped;
    in_ready         = !valid_r || out_ready;
    valid_nxt        = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // A remainder of 1000 or more means the reciprocal quotient came out one low.
  `NCE_ASSERT_IMP(a_rest_range, valid_r, data_r.rest < 10'd1000, "remainder out of range")

endmodule

/* rtl/core/nce_encode.sv */
// Output stage that turns both three-digit halves into the registered cathode words.
`include "six_digit_nixie_cathode_encoder_top_macros.svh"
module nce_encode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nce_pkg::part_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    upper_word,
  output logic [31:0]    lower_word,
  output logic           clamped
);
  import nce_pkg::*;

  logic        valid_r, valid_nxt;
  logic [63:0] pattern_r, pattern_nxt;
  logic        clamped_r;
  trio_t       hi, lo;

  always_comb begin
    hi          = to_trio(in_data.thou);
    lo          = to_trio(in_data.rest);
    pattern_nxt = cathode_mask(3'd0, hi.hund) | cathode_mask(3'd1, hi.tens)
                | cathode_mask(3'd2, hi.units) | cathode_mask(3'd3, lo.hund)
                | cathode_mask(3'd4, lo.tens) | cathode_mask(3'd5, lo.units);
    in_ready    = !valid_r || out_ready;
    valid_nxt   = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pattern_r <= pattern_nxt;
      clamped_r <= in_data.clamped;
    end
  end

  assign out_valid  = valid_r;
  assign upper_word = pattern_r[63:32];
  assign lower_word = pattern_r[31:0];
  assign clamped    = clamped_r;

  // Every tube lights exactly one cathode, and the tubes share no bit.
  `NCE_ASSERT_IMP(a_six_cathodes, valid_r, $countones(pattern_r) == 6, "cathode count wrong")

endmodule

/* rtl/core/six_digit_nixie_cathode_encoder_top.sv */
// An accepted item passes the thousands split, remainder and cathode output registers in
// turn to out_tvalid. Throughput: one item per cycle while out_tready is high; these and the
// input register form four stages, each of which can load every cycle.
// Reset (synchronous, rst_n low) empties all stages; the block holds no other state.
// in_tready drops only when every stage is full and the output item is not taken.
`include "six_digit_nixie_cathode_encoder_top_macros.svh"
module six_digit_nixie_cathode_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] value, [23:20] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] upper_word, [63:32] lower_word
  output logic        out_tuser   // [0] clamped
);
  import nce_pkg::*;

  // Input register: the raw number is captured here before any arithmetic.
  logic        in_valid_r, in_valid_nxt;
  logic [19:0] value_r;

  // Handshake and payload between the stages.
  logic   div_ready;
  logic   div_valid, rem_ready;
  split_t div_data;
  logic   rem_valid, enc_ready;
  part_t  rem_data;

  logic [31:0] upper_word;
  logic [31:0] lower_word;
  logic        clamped;

  always_comb begin
    in_tready    = !in_valid_r || div_ready;
    in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      value_r <= in_tdata[19:0];
    end
  end

  // Clamp to 999999 and take value / 1000 with an exact reciprocal multiply.
  nce_divk u_divk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_ready  (div_ready),
    .value     (value_r),
    .out_valid (div_valid),
    .out_ready (rem_ready),
    .out_data  (div_data)
  );

  // Remainder below one thousand, so both halves are three-digit numbers.
  nce_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (rem_ready),
    .in_data   (div_data),
    .out_valid (rem_valid),
    .out_ready (enc_ready),
    .out_data  (rem_data)
  );

  // Six digits, each mapped through its tube's cathode table; this is the output register.
  nce_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rem_valid),
    .in_ready   (enc_ready),
    .in_data    (rem_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .upper_word (upper_word),
    .lower_word (lower_word),
    .clamped    (clamped)
  );

  assign out_tdata = {lower_word, upper_word};
  assign out_tuser = clamped;

  // The input side stalls only when the whole pipeline is full behind a blocked output.
  `NCE_ASSERT_IMP(a_stall_cause, !in_tready, out_tvalid && !out_tready, "stall without backpressure")

endmodule
